// ----- hw/rtl/atan2pa_pkg.sv -----
// shared constants and types for the atan2 polynomial approximator
package atan2pa_pkg;

    // default geometry
    localparam int INPUT_WIDTH_DEF     = 16;
    localparam int ANGLE_FRAC_BITS_DEF = 13;

    // ratio a is unsigned Q1.15 in [0, 1.0]
    localparam int Q_FRAC  = 15;
    localparam int A_WIDTH = Q_FRAC + 1;

    // polynomial coefficients, Q1.15 magnitudes
    localparam logic [13:0] COEF_C1     = 14'd10736;
    localparam logic [12:0] COEF_C2     = 13'd5220;
    localparam logic [10:0] COEF_C3_MAG = 11'd1524;

    // pi in Q29
    localparam logic [63:0] PI_Q29 = 64'd1686629713;

    // octant and quadrant fold flags, carried alongside the data
    typedef struct packed {
        logic swap;   // |y| > |x|
        logic x_neg;
        logic y_neg;
        logic zero;   // both inputs zero
    } t_fold;

endpackage

// ----- hw/rtl/atan2_polynomial_approximator.sv -----
// top level: pipelined four-quadrant atan2 by ratio division and odd polynomial
//
// usage
//   input channel: drive i_y_value / i_x_value and raise start; a transaction
//   is taken at each rising edge with start high and busy low. busy is held
//   low, so a new coordinate pair may be presented on every cycle.
//   result channel: o_angle (signed, ANGLE_FRAC_BITS fraction bits, -pi..pi)
//   is shown for exactly one cycle with o_valid high. there is no back
//   pressure; the receiver must take every result in the cycle it appears.
//   pipeline: each input passes through 1 input stage, A_WIDTH+1 divider
//   stages, 6 polynomial stages and 2 fold stages before o_valid rises;
//   the depth is independent of INPUT_WIDTH.
//   throughput: one transaction per cycle, set by the fully pipelined
//   divider (one quotient bit per stage) and one multiplier per stage.
//   reset: synchronous, active low; it clears every valid bit so all items
//   in flight are dropped and no strobe follows. data registers are not
//   reset. both inputs zero yields an angle of zero.
module atan2_polynomial_approximator #(
    parameter int INPUT_WIDTH     = atan2pa_pkg::INPUT_WIDTH_DEF,
    parameter int ANGLE_FRAC_BITS = atan2pa_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic signed [INPUT_WIDTH-1:0]     i_y_value,
    input  logic signed [INPUT_WIDTH-1:0]     i_x_value,
    output logic                              o_valid,
    output logic signed [ANGLE_FRAC_BITS+2:0] o_angle
);
    import atan2pa_pkg::*;

    localparam int AW      = ANGLE_FRAC_BITS + 3;
    localparam int LATENCY = 1 + (A_WIDTH + 1) + 8;

    // pi and pi/2 rounded from the Q29 value
    localparam logic [63:0] PI_F64 = (ANGLE_FRAC_BITS >= 29) ? PI_Q29 :
        ((PI_Q29 + (64'd1 << (28 - ANGLE_FRAC_BITS))) >> (29 - ANGLE_FRAC_BITS));
    localparam logic [63:0] HALF_PI_F64 =
        (PI_Q29 + (64'd1 << (29 - ANGLE_FRAC_BITS))) >> (30 - ANGLE_FRAC_BITS);
    localparam logic signed [AW-1:0] PI_F      = AW'(PI_F64);
    localparam logic signed [AW-1:0] HALF_PI_F = AW'(HALF_PI_F64);

    // the pipeline never stalls
    assign busy = 1'b0;

    // ---------------------------------------------------------------
    // input stage: magnitudes, min/max and fold flags
    // ---------------------------------------------------------------
    logic [INPUT_WIDTH-1:0] n_ay;
    logic [INPUT_WIDTH-1:0] n_ax;
    logic                   n_swap;
    t_fold                  n_fold;

    assign n_ay   = i_y_value[INPUT_WIDTH-1] ? INPUT_WIDTH'(-i_y_value)
                                             : INPUT_WIDTH'(i_y_value);
    assign n_ax   = i_x_value[INPUT_WIDTH-1] ? INPUT_WIDTH'(-i_x_value)
                                             : INPUT_WIDTH'(i_x_value);
    assign n_swap = n_ay > n_ax;

    always_comb begin
        n_fold.swap  = n_swap;
        n_fold.x_neg = i_x_value[INPUT_WIDTH-1];
        n_fold.y_neg = i_y_value[INPUT_WIDTH-1];
        n_fold.zero  = (n_ay == '0) && (n_ax == '0);
    end

    logic                   r_in_vld;
    logic [INPUT_WIDTH-1:0] r_in_lo;
    logic [INPUT_WIDTH-1:0] r_in_hi;
    t_fold                  r_in_fold;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else begin
            r_in_vld <= start && !busy;
        end
        r_in_lo   <= n_swap ? n_ax : n_ay;
        r_in_hi   <= n_swap ? n_ay : n_ax;
        r_in_fold <= n_fold;
    end

    // ---------------------------------------------------------------
    // ratio a = round(lo / hi) in Q1.15
    // ---------------------------------------------------------------
    logic               w_div_vld;
    logic [A_WIDTH-1:0] w_div_a;
    t_fold              w_div_fold;

    atan2pa_div #(
        .DEN_WIDTH (INPUT_WIDTH),
        .QUO_WIDTH (A_WIDTH)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_in_vld),
        .i_lo    (r_in_lo),
        .i_den   (r_in_hi),
        .i_fold  (r_in_fold),
        .o_valid (w_div_vld),
        .o_quo   (w_div_a),
        .o_fold  (w_div_fold)
    );

    // ---------------------------------------------------------------
    // polynomial, one multiplier per stage; every product rounds half up
    // (all terms are kept as non-negative magnitudes)
    // ---------------------------------------------------------------
    logic               r_pv [1:8];
    t_fold              r_pf [1:8];
    logic [A_WIDTH-1:0] r_pa [1:5];

    logic [31:0] r_p1;   // a*a
    logic [15:0] r_s2;   // s
    logic [26:0] r_p2;   // c3*s
    logic [15:0] r_s3;
    logic [28:0] r_p3;   // t1*s
    logic [29:0] r_p4;   // t2*s magnitude
    logic [30:0] r_p5;   // t3*a magnitude
    logic [AW-1:0] r_r6; // rescaled r

    logic [31:0] n_s2_sum;
    logic [15:0] n_s2;
    logic [26:0] n_m3_sum;
    logic [12:0] n_t1;
    logic [28:0] n_m4_sum;
    logic [13:0] n_t2;
    logic [29:0] n_m5_sum;
    logic [14:0] n_t3;
    logic [30:0] n_m6_sum;
    logic [15:0] n_r6;
    logic [AW-1:0] n_r6_scaled;

    assign n_s2_sum = r_p1 + 32'd16384;
    assign n_s2     = n_s2_sum[30:15];
    assign n_m3_sum = r_p2 + 27'd16384;
    assign n_t1     = COEF_C2 - {1'b0, n_m3_sum[26:15]};
    assign n_m4_sum = r_p3 + 29'd16384;
    assign n_t2     = COEF_C1 - n_m4_sum[28:15];
    assign n_m5_sum = r_p4 + 30'd16384;
    assign n_t3     = n_m5_sum[29:15];
    assign n_m6_sum = r_p5 + 31'd16384;
    assign n_r6     = r_pa[5] - n_m6_sum[30:15];

    // rescale from Q15 to the angle format
    if (ANGLE_FRAC_BITS >= Q_FRAC) begin : g_up
        assign n_r6_scaled = AW'(n_r6) << (ANGLE_FRAC_BITS - Q_FRAC);
    end else begin : g_dn
        localparam int DN = Q_FRAC - ANGLE_FRAC_BITS;
        logic [16:0] n_rnd;
        assign n_rnd       = {1'b0, n_r6} + 17'(1 << (DN - 1));
        assign n_r6_scaled = AW'(n_rnd >> DN);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv[1] <= 1'b0;
        end else begin
            r_pv[1] <= w_div_vld;
        end
        r_pf[1] <= w_div_fold;
        r_pa[1] <= w_div_a;
        r_p1    <= 32'(w_div_a) * 32'(w_div_a);
    end

    for (genvar k = 2; k <= 8; k++) begin : g_pipe
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_pv[k] <= 1'b0;
            end else begin
                r_pv[k] <= r_pv[k-1];
            end
            r_pf[k] <= r_pf[k-1];
        end
    end

    for (genvar k = 2; k <= 5; k++) begin : g_apipe
        always_ff @(posedge i_clk) begin
            r_pa[k] <= r_pa[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2 <= n_s2;
        r_p2 <= 27'(n_s2) * 27'(COEF_C3_MAG);
        r_s3 <= r_s2;
        r_p3 <= 29'(n_t1) * 29'(r_s2);
        r_p4 <= 30'(n_t2) * 30'(r_s3);
        r_p5 <= 31'(n_t3) * 31'(r_pa[4]);
        r_r6 <= n_r6_scaled;
    end

    // ---------------------------------------------------------------
    // fold into octant and quadrant
    // ---------------------------------------------------------------
    logic signed [AW-1:0] n_oct;
    logic signed [AW-1:0] n_quad;
    logic signed [AW-1:0] r_f7;
    logic signed [AW-1:0] r_out;

    assign n_oct  = r_pf[6].swap ? (HALF_PI_F - $signed(r_r6)) : $signed(r_r6);
    assign n_quad = r_pf[6].x_neg ? (PI_F - n_oct) : n_oct;

    always_ff @(posedge i_clk) begin
        r_f7 <= n_quad;
        if (r_pf[7].zero) begin
            r_out <= '0;
        end else if (r_pf[7].y_neg) begin
            r_out <= -r_f7;
        end else begin
            r_out <= r_f7;
        end
    end

    assign o_valid = r_pv[8];
    assign o_angle = r_out;

`ifndef SYNTHESIS
    // every accepted transaction yields exactly one strobe after the latency
    a_lat_fwd : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##(LATENCY) o_valid)
        else $error("accepted transaction gave no result");

    a_lat_bwd : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, LATENCY))
        else $error("result strobe without an accepted transaction");

    // origin maps to zero angle
    a_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_y_value == '0) && (i_x_value == '0))
            |-> ##(LATENCY) (o_angle == '0))
        else $error("zero input gave nonzero angle");

    // angle stays within -pi..pi
    a_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_angle <= PI_F) && (o_angle >= -PI_F)))
        else $error("angle out of range");
`endif

endmodule

// ----- hw/rtl/atan2pa_div.sv -----
// pipelined restoring divider, one quotient bit per stage, rounded ratio lo/hi
module atan2pa_div #(
    parameter int DEN_WIDTH = atan2pa_pkg::INPUT_WIDTH_DEF,
    parameter int QUO_WIDTH = atan2pa_pkg::A_WIDTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic [DEN_WIDTH-1:0]  i_lo,
    input  logic [DEN_WIDTH-1:0]  i_den,
    input  atan2pa_pkg::t_fold    i_fold,
    output logic                  o_valid,
    output logic [QUO_WIDTH-1:0]  o_quo,
    output atan2pa_pkg::t_fold    o_fold
);
    import atan2pa_pkg::*;

    localparam int NUM_WIDTH = DEN_WIDTH + QUO_WIDTH;

    logic                 r_vld  [0:QUO_WIDTH];
    logic [DEN_WIDTH-1:0] r_rem  [0:QUO_WIDTH];
    logic [QUO_WIDTH-1:0] r_nlo  [0:QUO_WIDTH];
    logic [DEN_WIDTH-1:0] r_den  [0:QUO_WIDTH];
    logic [QUO_WIDTH-1:0] r_quo  [0:QUO_WIDTH];
    t_fold                r_fold [0:QUO_WIDTH];

    // numerator lo * 2^(QUO_WIDTH-1) + hi/2 gives round to nearest
    logic [NUM_WIDTH-1:0] n_num;
    assign n_num = {1'b0, i_lo, {(QUO_WIDTH-1){1'b0}}} + NUM_WIDTH'(i_den >> 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= i_valid;
        end
        r_rem[0]  <= n_num[NUM_WIDTH-1:QUO_WIDTH];
        r_nlo[0]  <= n_num[QUO_WIDTH-1:0];
        r_den[0]  <= i_den;
        r_quo[0]  <= '0;
        r_fold[0] <= i_fold;
    end

    for (genvar k = 1; k <= QUO_WIDTH; k++) begin : g_stage
        logic [DEN_WIDTH:0]   n_shift;
        logic [DEN_WIDTH:0]   n_diff;
        logic                 n_bit;
        logic [DEN_WIDTH-1:0] n_rem;

        assign n_shift = {r_rem[k-1], r_nlo[k-1][QUO_WIDTH-1]};
        assign n_diff  = n_shift - {1'b0, r_den[k-1]};
        assign n_bit   = ~n_diff[DEN_WIDTH];
        assign n_rem   = n_bit ? n_diff[DEN_WIDTH-1:0] : n_shift[DEN_WIDTH-1:0];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= r_vld[k-1];
            end
            r_rem[k]  <= n_rem;
            r_nlo[k]  <= {r_nlo[k-1][QUO_WIDTH-2:0], 1'b0};
            r_den[k]  <= r_den[k-1];
            r_quo[k]  <= {r_quo[k-1][QUO_WIDTH-2:0], n_bit};
            r_fold[k] <= r_fold[k-1];
        end
    end

    assign o_valid = r_vld[QUO_WIDTH];
    assign o_quo   = r_quo[QUO_WIDTH];
    assign o_fold  = r_fold[QUO_WIDTH];

endmodule

// ----- tb/sv/tb_atan2_polynomial_approximator.sv -----
// self-checking testbench for the pipelined atan2 polynomial approximator
module tb_atan2_polynomial_approximator;
    timeunit 1ns;
    timeprecision 1ps;

    import atan2pa_pkg::*;

    // geometry follows the block defaults
    localparam int IW = INPUT_WIDTH_DEF;
    localparam int AFB = ANGLE_FRAC_BITS_DEF;
    localparam int AW = AFB + 3;

    localparam int CLK_PERIOD = 10;
    localparam int RESET_CYCLES = 11;
    // pipeline is 26 stages deep, give it some slack after the last strobe
    localparam int DRAIN_CYCLES = 40;
    // far above the slowest legal run (~1700 transactions, half idle, plus latency)
    localparam longint TIMEOUT_NS = 2_000_000;

    localparam int N_DIRECTED = 24;

    typedef logic signed [IW-1:0] t_sample;
    typedef logic signed [AW-1:0] t_angle;

    // holds the angles still owed by the pipeline, oldest first, and checks
    // each strobe against the head of that list
    class angle_ledger;
        t_angle due_angles[$];
        int unsigned mismatches;

        function new();
            mismatches = 0;
        endfunction

        // q1.15 product, halves rounded away from zero
        static function longint q15_product(longint p, longint q);
            longint v;
            v = p * q;
            if (v >= 0)
                return (v + (longint'(1) << (Q_FRAC - 1))) >>> Q_FRAC;
            return -(((-v) + (longint'(1) << (Q_FRAC - 1))) >>> Q_FRAC);
        endfunction

        // expected four-quadrant angle for one coordinate pair
        static function t_angle atan2_fixed(t_sample y, t_sample x);
            longint ys, xs, ay, ax, lo, hi;
            longint a, s, t, r, pi_f, half_pi_f;
            int shift;
            ys = longint'(y);
            xs = longint'(x);
            ay = (ys < 0) ? -ys : ys;
            ax = (xs < 0) ? -xs : xs;
            lo = (ay < ax) ? ay : ax;
            hi = (ay < ax) ? ax : ay;
            pi_f = (longint'(PI_Q29) + (longint'(1) << (28 - AFB))) >>> (29 - AFB);
            half_pi_f = (longint'(PI_Q29) + (longint'(1) << (29 - AFB))) >>> (30 - AFB);

            if (hi == 0)
                return '0;

            // ratio in q1.15, rounded to nearest
            a = ((lo << Q_FRAC) + (hi >> 1)) / hi;
            if (a > (longint'(1) << Q_FRAC))
                a = longint'(1) << Q_FRAC;

            // odd polynomial a + a*s*((c3*s + c2)*s - c1), c3 negative
            s = q15_product(a, a);
            t = longint'(COEF_C2) - q15_product(longint'(COEF_C3_MAG), s);
            t = q15_product(t, s) - longint'(COEF_C1);
            t = q15_product(t, s);
            r = a + q15_product(t, a);

            // q1.15 to the angle scale
            shift = AFB - Q_FRAC;
            if (shift >= 0)
                r = r <<< shift;
            else
                r = (r + (longint'(1) << (-shift - 1))) >>> (-shift);

            // octant, then quadrant, then sign of y
            if (ay > ax)
                r = half_pi_f - r;
            if (xs < 0)
                r = pi_f - r;
            if (ys < 0)
                r = -r;
            return r[AW-1:0];
        endfunction

        function void record_pair(t_sample y, t_sample x);
            due_angles.push_back(atan2_fixed(y, x));
        endfunction

        function void check_angle(t_angle got);
            t_angle want;
            if (due_angles.size() == 0) begin
                $display("%0t: angle %0d strobed with no transaction outstanding", $time, got);
                mismatches++;
                return;
            end
            want = due_angles.pop_front();
            if (got !== want) begin
                $display("%0t: angle mismatch, expected %0d, actual %0d", $time, want, got);
                mismatches++;
            end
        endfunction

        function int unsigned pending();
            return due_angles.size();
        endfunction
    endclass

    // ---------------------------------------------------------------
    // clock, reset and block inputs, all known from time zero
    // ---------------------------------------------------------------
    logic    i_clk = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    start = 1'b0;
    t_sample i_y_value = '0;
    t_sample i_x_value = '0;
    logic    busy;
    logic    o_valid;
    t_angle  o_angle;

    angle_ledger ledger;

    // corner pairs: zero/zero, the axes, both extremes, equal magnitudes in
    // all four quadrants, near-zero ratios on either side of the diagonal
    int directed_y [N_DIRECTED] = '{
        0, 0, 0, 0, 0, 1, -1, 32767, -32768, 32767, -32768, -32768,
        32767, 100, -100, 100, -100, 1, 32767, -1, -32768, 5, 12345, -7
    };
    int directed_x [N_DIRECTED] = '{
        0, 1, -1, 32767, -32768, 0, 0, 0, 0, 32767, -32768, 32767,
        -32768, 100, 100, -100, -100, 32767, 1, -32768, -1, -3, -23456, 7
    };

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    atan2_polynomial_approximator dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .busy      (busy),
        .i_y_value (i_y_value),
        .i_x_value (i_x_value),
        .o_valid   (o_valid),
        .o_angle   (o_angle)
    );

    // ---------------------------------------------------------------
    // monitor: everything is sampled at the rising edge, before the
    // block's own registers update in that step
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            // an accepted transaction becomes one owed angle
            if (start && !busy)
                ledger.record_pair(i_y_value, i_x_value);
            // no back pressure: every strobe must be matched right away
            if (o_valid === 1'b1)
                ledger.check_angle(o_angle);
        end
    end

    // ---------------------------------------------------------------
    // driver tasks: inputs only move on the falling edge
    // ---------------------------------------------------------------

    // present one pair and hold it until a rising edge sees busy low
    task automatic send_pair(t_sample y, t_sample x);
        @(negedge i_clk);
        start <= 1'b1;
        i_y_value <= y;
        i_x_value <= x;
        do
            @(posedge i_clk);
        while (busy);
    endtask

    // an idle cycle with start low; data wiggles to show it is ignored
    task automatic idle_cycle();
        @(negedge i_clk);
        start <= 1'b0;
        i_y_value <= t_sample'($urandom);
        i_x_value <= t_sample'($urandom);
    endtask

    // random pair, biased toward the interesting regions of the fold
    task automatic pick_pair(output t_sample y, output t_sample x);
        int unsigned mode;
        int unsigned mag;
        mode = $urandom_range(0, 9);
        y = t_sample'($urandom);
        x = t_sample'($urandom);
        case (mode)
            6: begin
                // equal magnitudes, ratio exactly one
                mag = $urandom_range(0, 32767);
                y = $urandom_range(0, 1) ? -t_sample'(mag) : t_sample'(mag);
                x = $urandom_range(0, 1) ? -t_sample'(mag) : t_sample'(mag);
            end
            7: begin
                // one component zero, on an axis
                if ($urandom_range(0, 1))
                    y = '0;
                else
                    x = '0;
            end
            8: begin
                // tiny magnitudes, coarse ratios and zero/zero now and then
                y = t_sample'($signed($urandom_range(0, 16)) - 8);
                x = t_sample'($signed($urandom_range(0, 16)) - 8);
            end
            9: begin
                // one component at an extreme
                if ($urandom_range(0, 1))
                    y = $urandom_range(0, 1) ? t_sample'(-32768) : t_sample'(32767);
                else
                    x = $urandom_range(0, 1) ? t_sample'(-32768) : t_sample'(32767);
            end
            default: begin
                // full-range random pair, already drawn
            end
        endcase
    endtask

    // a run of random transactions, sender idle idle_pct cycles out of 100
    task automatic run_phase(int count, int unsigned idle_pct);
        t_sample y;
        t_sample x;
        for (int i = 0; i < count; i++) begin
            while ($urandom_range(0, 99) < idle_pct)
                idle_cycle();
            pick_pair(y, x);
            send_pair(y, x);
        end
    endtask

    // ---------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------
    initial begin
        ledger = new();

        // single reset at the start of the run
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed corners, back to back
        for (int i = 0; i < N_DIRECTED; i++)
            send_pair(t_sample'(directed_y[i]), t_sample'(directed_x[i]));

        // random phases: full rate, heavy sender gaps, light gaps, full rate
        run_phase(400, 0);
        run_phase(450, 53);
        run_phase(450, 29);
        run_phase(400, 0);

        @(negedge i_clk);
        start <= 1'b0;

        // wait for every owed angle, then watch for stray strobes
        while (ledger.pending() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (ledger.mismatches == 0 && ledger.pending() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // watchdog against a hung pipeline
    initial begin
        #(TIMEOUT_NS);
        $display("%0t: timeout, %0d angles still outstanding", $time, ledger.pending());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/atan2pa_pkg.sv
hw/rtl/atan2pa_div.sv
hw/rtl/atan2_polynomial_approximator.sv
tb/sv/tb_atan2_polynomial_approximator.sv
